// ----- rtl/core/mpct_pkg.sv -----
// Shared types, constants and size helpers for the mouse packet cursor tracker.
package mpct_pkg;

    // Cursor coordinate width; the output ports follow it.
    localparam int C_COORD_BITS = 12;
    localparam int C_COORD_MAX  = (1 << C_COORD_BITS) - 1;

    // Fixed register field widths.
    localparam int C_SIZE_BITS  = 13;
    localparam int C_SCALE_BITS = 4;
    localparam int C_INDEX_BITS = 2;

    // Scaled delta: 9-bit signed move times a 4-bit scale.
    localparam int C_DELTA_BITS = 14;
    localparam int C_SUM_BITS   =
        ((C_COORD_BITS > C_DELTA_BITS) ? C_COORD_BITS : C_DELTA_BITS) + 2;

    // Width that holds both a raw size and 2^C_COORD_BITS.
    localparam int C_WIDE_BITS  =
        (C_SIZE_BITS > C_COORD_BITS + 1) ? C_SIZE_BITS : C_COORD_BITS + 1;

    typedef logic [C_COORD_BITS-1:0] t_coord;
    typedef logic [C_SIZE_BITS-1:0]  t_size;
    typedef logic [C_SCALE_BITS-1:0] t_scale;

    // Register indexes on the configuration port.
    localparam logic [C_INDEX_BITS-1:0] C_REG_WIDTH  = 2'd0;
    localparam logic [C_INDEX_BITS-1:0] C_REG_HEIGHT = 2'd1;
    localparam logic [C_INDEX_BITS-1:0] C_REG_SCALE  = 2'd2;

    // Byte position inside a packet.
    localparam logic [1:0] C_CNT_FLAG = 2'd0;
    localparam logic [1:0] C_CNT_X    = 2'd1;
    localparam logic [1:0] C_CNT_Y    = 2'd2;

    // Flag byte bit positions.
    localparam int C_FLAG_SYNC  = 3;
    localparam int C_FLAG_XSIGN = 4;
    localparam int C_FLAG_YSIGN = 5;
    localparam int C_FLAG_XOVF  = 6;
    localparam int C_FLAG_YOVF  = 7;
    localparam int C_BTN_BITS   = 3;

    // Scale limits.
    localparam t_scale C_SCALE_MIN = t_scale'(1);
    localparam t_scale C_SCALE_MAX = t_scale'(8);
    localparam t_scale C_RST_SCALE = t_scale'(2);

    // Reset position and limits, saturated to the coordinate range.
    localparam int C_RST_X_INT   = (400 > C_COORD_MAX) ? C_COORD_MAX : 400;
    localparam int C_RST_Y_INT   = (300 > C_COORD_MAX) ? C_COORD_MAX : 300;
    localparam int C_RST_XT_INT  = (1919 > C_COORD_MAX) ? C_COORD_MAX : 1919;
    localparam int C_RST_YT_INT  = (1079 > C_COORD_MAX) ? C_COORD_MAX : 1079;
    localparam t_coord C_RST_X     = t_coord'(C_RST_X_INT);
    localparam t_coord C_RST_Y     = t_coord'(C_RST_Y_INT);
    localparam t_coord C_RST_X_TOP = t_coord'(C_RST_XT_INT);
    localparam t_coord C_RST_Y_TOP = t_coord'(C_RST_YT_INT);

    // Sign and overflow bits of one axis, taken from the flag byte.
    typedef struct packed {
        logic sign;
        logic ovf;
    } t_axis_flags;

    // Highest legal coordinate for a size register value.
    function automatic t_coord size_top(input t_size w);
        logic [C_WIDE_BITS-1:0] wv;
        logic [C_WIDE_BITS-1:0] lim;
        wv  = C_WIDE_BITS'(w);
        lim = C_WIDE_BITS'(1) << C_COORD_BITS;
        if (wv == '0) begin
            return '0;
        end else if (wv > lim) begin
            return t_coord'(lim - C_WIDE_BITS'(1));
        end else begin
            return t_coord'(wv - C_WIDE_BITS'(1));
        end
    endfunction

    // Center coordinate for a size register value.
    function automatic t_coord size_half(input t_size w);
        logic [C_WIDE_BITS-1:0] wv;
        logic [C_WIDE_BITS-1:0] lim;
        wv  = C_WIDE_BITS'(w);
        lim = C_WIDE_BITS'(1) << C_COORD_BITS;
        if (wv > lim) begin
            return t_coord'(lim >> 1);
        end else begin
            return t_coord'(wv >> 1);
        end
    endfunction

endpackage

// ----- rtl/core/mouse_packet_cursor_tracker.sv -----
// Top level of the mouse packet cursor tracker.
//
// Takes one raw mouse byte per cycle and groups bytes into three-byte packets
// (flags, X move, Y move); a leading byte with bit 3 clear is dropped. On the
// third byte the cursor moves by the scaled signed deltas (Y downward) and is
// clamped to the screen, and one item with position and buttons is sent out.
// A byte is held in the input register while the update is worked out, and a
// packet's result is loaded into the output register once its last byte is
// processed; bytes are taken every cycle while the output register can drain.
// Writing screen_width or screen_height re-centers that axis; motion_scale is
// held in 1..8. Reset puts the cursor at (400, 300) with a 1920x1080 screen
// and scale 2. Write configuration only while the block is idle.
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input bytes
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_data_byte,
    // cursor items
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [C_COORD_BITS-1:0] o_cursor_x,
    output logic [C_COORD_BITS-1:0] o_cursor_y,
    output logic [C_BTN_BITS-1:0]   o_buttons,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [C_INDEX_BITS-1:0] i_cfg_index,
    input  logic [C_SIZE_BITS-1:0]  i_cfg_data
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [1:0]            r_count;
    logic [1:0]            n_count;
    logic [7:0]            r_flag_byte;
    logic [7:0]            r_x_byte;
    t_coord                r_pos_x;
    t_coord                r_pos_y;
    t_coord                r_x_top;
    t_coord                r_y_top;
    t_scale                r_scale;
    logic                  r_out_valid;
    t_coord                r_out_x;
    t_coord                r_out_y;
    logic [C_BTN_BITS-1:0] r_out_btn;

    logic                  in_take;
    logic                  fire;
    logic                  last_byte;
    logic                  cfg_take;
    t_scale                cfg_scale;
    t_coord                new_x;
    t_coord                new_y;
    t_axis_flags           x_flags;
    t_axis_flags           y_flags;

    // Handshakes: process the held byte; a last byte waits until the output slot can take a result
    assign last_byte   = (r_count == C_CNT_Y);
    assign fire        = r_in_valid && (!last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;

    // Hold the incoming byte until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !fire);
        end
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Advance through the packet; a third byte always ends it
    always_comb begin
        unique case (r_count)
            C_CNT_X: n_count = C_CNT_Y;
            C_CNT_Y: n_count = C_CNT_FLAG;
            default: n_count = r_in_byte[C_FLAG_SYNC] ? C_CNT_X : C_CNT_FLAG;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= C_CNT_FLAG;
        end else if (fire) begin
            r_count <= n_count;
        end
    end

    // Keep the flag and X bytes of the current packet
    always_ff @(posedge i_clk) begin
        if (fire && (r_count == C_CNT_X)) begin
            r_x_byte <= r_in_byte;
        end
        if (fire && (r_count != C_CNT_X) && (r_count != C_CNT_Y)
            && r_in_byte[C_FLAG_SYNC]) begin
            r_flag_byte <= r_in_byte;
        end
    end

    // Axis updates
    assign x_flags = '{sign: r_flag_byte[C_FLAG_XSIGN], ovf: r_flag_byte[C_FLAG_XOVF]};
    assign y_flags = '{sign: r_flag_byte[C_FLAG_YSIGN], ovf: r_flag_byte[C_FLAG_YOVF]};

    mpct_axis u_axis_x (
        .i_pos       (r_pos_x),
        .i_move_byte (r_x_byte),
        .i_flags     (x_flags),
        .i_negate    (1'b0),
        .i_scale     (r_scale),
        .i_top       (r_x_top),
        .o_pos       (new_x)
    );

    mpct_axis u_axis_y (
        .i_pos       (r_pos_y),
        .i_move_byte (r_in_byte),
        .i_flags     (y_flags),
        .i_negate    (1'b1),
        .i_scale     (r_scale),
        .i_top       (r_y_top),
        .o_pos       (new_y)
    );

    // Clamp the written scale into range
    always_comb begin
        priority if (t_scale'(i_cfg_data) < C_SCALE_MIN) begin
            cfg_scale = C_SCALE_MIN;
        end else if (t_scale'(i_cfg_data) > C_SCALE_MAX) begin
            cfg_scale = C_SCALE_MAX;
        end else begin
            cfg_scale = t_scale'(i_cfg_data);
        end
    end

    // Cursor position and screen limits; a size write re-centers its axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= C_RST_X;
            r_pos_y <= C_RST_Y;
            r_x_top <= C_RST_X_TOP;
            r_y_top <= C_RST_Y_TOP;
            r_scale <= C_RST_SCALE;
        end else if (cfg_take) begin
            unique case (i_cfg_index)
                C_REG_WIDTH: begin
                    r_x_top <= size_top(i_cfg_data);
                    r_pos_x <= size_half(i_cfg_data);
                end
                C_REG_HEIGHT: begin
                    r_y_top <= size_top(i_cfg_data);
                    r_pos_y <= size_half(i_cfg_data);
                end
                C_REG_SCALE: begin
                    r_scale <= cfg_scale;
                end
                default: begin
                end
            endcase
        end else if (fire && last_byte) begin
            r_pos_x <= new_x;
            r_pos_y <= new_y;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire && last_byte) begin
            r_out_x   <= new_x;
            r_out_y   <= new_y;
            r_out_btn <= r_flag_byte[C_BTN_BITS-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_out_x;
    assign o_cursor_y  = r_out_y;
    assign o_buttons   = r_out_btn;

    // A completed packet always leaves a result waiting
    a_last_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last_byte |=> r_out_valid)
        else $error("packet end did not load the result register");

    // The cursor never leaves the screen
    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_x <= r_x_top)
        else $error("cursor x beyond screen width");

    a_y_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_y <= r_y_top)
        else $error("cursor y beyond screen height");

    // A held byte that was not processed stays in place
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_count))
        else $error("held byte lost or changed");

endmodule

// ----- rtl/core/mpct_axis.sv -----
// One cursor axis: builds the signed move, scales it, applies it and clamps.
module mpct_axis
    import mpct_pkg::*;
(
    input  t_coord      i_pos,
    input  logic [7:0]  i_move_byte,
    input  t_axis_flags i_flags,
    input  logic        i_negate,
    input  t_scale      i_scale,
    input  t_coord      i_top,
    output t_coord      o_pos
);

    logic signed [8:0]              delta;
    logic signed [C_DELTA_BITS-1:0] scaled;
    logic signed [C_SUM_BITS-1:0]   pos_ext;
    logic signed [C_SUM_BITS-1:0]   top_ext;
    logic signed [C_SUM_BITS-1:0]   move_ext;
    logic signed [C_SUM_BITS-1:0]   sum;

    // Form the 9-bit move, drop it on overflow, and scale it
    always_comb begin
        delta    = i_flags.ovf ? 9'sd0 : $signed({i_flags.sign, i_move_byte});
        scaled   = C_DELTA_BITS'(delta * $signed({1'b0, i_scale}));
        move_ext = C_SUM_BITS'(scaled);
        pos_ext  = $signed(C_SUM_BITS'(i_pos));
        top_ext  = $signed(C_SUM_BITS'(i_top));
        sum      = i_negate ? (pos_ext - move_ext) : (pos_ext + move_ext);
    end

    // Clamp to the screen
    always_comb begin
        priority if (sum < 0) begin
            o_pos = '0;
        end else if (sum > top_ext) begin
            o_pos = i_top;
        end else begin
            o_pos = t_coord'(sum);
        end
    end

endmodule

// ----- dv/mpct_checker.sv -----
`timescale 1ns / 100ps
// Checker for the mouse packet cursor tracker: tracks packets, predicts cursor items, compares.
module mpct_checker
    import mpct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte channel
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [7:0]              i_data_byte,
    // cursor channel
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  t_coord                  i_cursor_x,
    input  t_coord                  i_cursor_y,
    input  logic [C_BTN_BITS-1:0]   i_buttons,
    // register writes
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [C_INDEX_BITS-1:0] i_cfg_index,
    input  logic [C_SIZE_BITS-1:0]  i_cfg_data,
    // status for the top
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam t_size C_RST_WIDTH  = t_size'(1920);
    localparam t_size C_RST_HEIGHT = t_size'(1080);

    typedef struct packed {
        t_coord                x;
        t_coord                y;
        logic [C_BTN_BITS-1:0] buttons;
    } t_cursor;

    t_cursor expected_cursors[$];

    // Shadow of the block's state and registers
    logic [1:0] byte_pos;
    logic [7:0] flags_held;
    logic [7:0] dx_held;
    t_coord     cur_x;
    t_coord     cur_y;
    t_size      width_reg;
    t_size      height_reg;
    t_scale     scale_reg;
    int         fails;

    // Usable extent of an axis: zero acts as one, oversize saturates
    function automatic int extent(input t_size s);
        int v;
        v = int'(s);
        if (v < 1) begin
            return 1;
        end
        if (v > (1 << C_COORD_BITS)) begin
            return 1 << C_COORD_BITS;
        end
        return v;
    endfunction

    // Signed 9-bit move, zeroed on overflow, times the scale
    function automatic int scaled_move(input logic [7:0] mag, input logic neg,
                                       input logic ovf, input t_scale k);
        int d;
        d = int'(mag);
        if (neg) begin
            d = d - 256;
        end
        if (ovf) begin
            d = 0;
        end
        return d * int'(k);
    endfunction

    function automatic t_coord clamp_to(input int v, input t_size s);
        int top;
        top = extent(s) - 1;
        if (v < 0) begin
            return '0;
        end
        if (v > top) begin
            return t_coord'(top);
        end
        return t_coord'(v);
    endfunction

    task automatic reset_tracker();
        byte_pos   = C_CNT_FLAG;
        flags_held = '0;
        dx_held    = '0;
        cur_x      = C_RST_X;
        cur_y      = C_RST_Y;
        width_reg  = C_RST_WIDTH;
        height_reg = C_RST_HEIGHT;
        scale_reg  = C_RST_SCALE;
        expected_cursors.delete();
    endtask

    // Apply a register write; sizes re-center their own axis
    task automatic write_register(input logic [C_INDEX_BITS-1:0] idx,
                                  input logic [C_SIZE_BITS-1:0] data);
        t_scale k;
        case (idx)
            C_REG_WIDTH: begin
                width_reg = data;
                cur_x     = t_coord'(extent(data) / 2);
            end
            C_REG_HEIGHT: begin
                height_reg = data;
                cur_y      = t_coord'(extent(data) / 2);
            end
            C_REG_SCALE: begin
                k = data[C_SCALE_BITS-1:0];
                if (k < C_SCALE_MIN) begin
                    k = C_SCALE_MIN;
                end
                if (k > C_SCALE_MAX) begin
                    k = C_SCALE_MAX;
                end
                scale_reg = k;
            end
            default: begin
                // unknown index: no effect
            end
        endcase
    endtask

    // Advance the packet assembly by one byte; a third byte yields a cursor item
    task automatic track_byte(input logic [7:0] b);
        int      dx;
        int      dy;
        t_cursor item;
        case (byte_pos)
            C_CNT_X: begin
                dx_held  = b;
                byte_pos = C_CNT_Y;
            end
            C_CNT_Y: begin
                byte_pos = C_CNT_FLAG;
                dx = scaled_move(dx_held, flags_held[C_FLAG_XSIGN],
                                 flags_held[C_FLAG_XOVF], scale_reg);
                dy = scaled_move(b, flags_held[C_FLAG_YSIGN],
                                 flags_held[C_FLAG_YOVF], scale_reg);
                cur_x = clamp_to(int'(cur_x) + dx, width_reg);
                cur_y = clamp_to(int'(cur_y) - dy, height_reg);
                item.x       = cur_x;
                item.y       = cur_y;
                item.buttons = flags_held[C_BTN_BITS-1:0];
                expected_cursors.push_back(item);
            end
            default: begin
                // drop a leading byte without the sync bit
                if (b[C_FLAG_SYNC]) begin
                    flags_held = b;
                    byte_pos   = C_CNT_X;
                end else begin
                    byte_pos = C_CNT_FLAG;
                end
            end
        endcase
    endtask

    // Compare one cursor item against the oldest prediction
    task automatic check_cursor();
        t_cursor exp;
        if (expected_cursors.size() == 0) begin
            $display("%0t mpct_checker: unexpected item x=%0d y=%0d buttons=%0d",
                     $time, i_cursor_x, i_cursor_y, i_buttons);
            fails++;
        end else begin
            exp = expected_cursors.pop_front();
            if (i_cursor_x !== exp.x) begin
                $display("%0t mpct_checker: cursor_x expected %0d actual %0d",
                         $time, exp.x, i_cursor_x);
                fails++;
            end
            if (i_cursor_y !== exp.y) begin
                $display("%0t mpct_checker: cursor_y expected %0d actual %0d",
                         $time, exp.y, i_cursor_y);
                fails++;
            end
            if (i_buttons !== exp.buttons) begin
                $display("%0t mpct_checker: buttons expected %0d actual %0d",
                         $time, exp.buttons, i_buttons);
                fails++;
            end
        end
    endtask

    // Watch all three channels; check outputs before taking new bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_cursor();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                track_byte(i_data_byte);
            end
        end
        o_pending    <= expected_cursors.size();
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the mouse packet cursor tracker: stimulus, idling, watchdog and verdict.
module tb;
    import mpct_pkg::*;

    localparam int C_HOLD_OFF     = 4;
    localparam int C_QUIET_LIMIT  = 2000;
    localparam int C_RANDOM_ITEMS = 1450;
    localparam int C_PHASES       = 10;
    localparam logic [C_INDEX_BITS-1:0] C_REG_SPARE = 2'd3;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [7:0]              i_data_byte = '0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [C_INDEX_BITS-1:0] i_cfg_index = C_REG_WIDTH;
    logic [C_SIZE_BITS-1:0]  i_cfg_data  = '0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    t_coord                  o_cursor_x;
    t_coord                  o_cursor_y;
    logic [C_BTN_BITS-1:0]   o_buttons;
    logic                    o_cfg_ready;

    int fail_count;
    int pending_count;
    int stall_max  = 0;
    int stall_run  = 0;
    int gap_max    = 0;
    int burst_left = 0;
    int sent_count = 0;

    mouse_packet_cursor_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_buttons   (o_buttons),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mpct_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_cursor_x   (o_cursor_x),
        .i_cursor_y   (o_cursor_y),
        .i_buttons    (o_buttons),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the cursor channel in runs; stall_max of zero leaves it open
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (stall_max == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !i_out_stall;
            stall_run   <= i_out_stall ? $urandom_range(0, 12) : $urandom_range(0, stall_max);
        end
    end

    // End the run when no channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < C_QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: errors");
        $finish;
    end

    // Send one item, opening a new burst after a random gap when the last one ran out
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        push_byte(flags);
        push_byte(dx);
        push_byte(dy);
    endtask

    // Hold the sender until every cursor item is out, then let the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (C_HOLD_OFF) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [C_INDEX_BITS-1:0] idx,
                             input logic [C_SIZE_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Flag byte with sync set; overflow bits mostly clear so moves get through
    function automatic logic [7:0] draw_flags();
        logic [7:0] f;
        f = 8'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            f[C_FLAG_YOVF:C_FLAG_XOVF] = 2'b00;
        end
        f[C_FLAG_SYNC] = 1'b1;
        return f;
    endfunction

    function automatic logic [7:0] draw_move();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 7));
            1:       return 8'($urandom_range(8'hF8, 8'hFF));
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly whole packets, with stray bytes and cut-off packets mixed in
    task automatic run_traffic(input int quota);
        int start;
        int kind;
        start = sent_count;
        while (sent_count - start < quota) begin
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
                send_packet(draw_flags(), draw_move(), draw_move());
            end else if (kind < 18) begin
                push_byte(8'($urandom));
            end else begin
                push_byte(draw_flags());
                push_byte(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int p;
        int w;
        int h;
        int s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray bytes, reset settings, sign, overflow and clamp cases
        push_byte(8'h00);
        push_byte(8'hF7);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h0F, 8'h7F, 8'h7F);
        send_packet(8'h38, 8'h80, 8'h80);
        send_packet(8'hC8, 8'hFF, 8'hFF);
        send_packet(8'h19, 8'h00, 8'h01);
        send_packet(8'h2A, 8'h01, 8'h00);
        send_packet(8'h4C, 8'h10, 8'h10);
        wait_idle();

        // Random phases, each under its own screen and scale setting
        sent_count = 0;
        for (p = 0; p < C_PHASES; p++) begin
            case (p)
                0:       begin w = 0;    h = 1;    s = 0;  end
                1:       begin w = 4096; h = 4096; s = 8;  end
                2:       begin w = 8191; h = 4097; s = 15; end
                3:       begin w = 1;    h = 0;    s = 9;  end
                4:       begin w = 640;  h = 480;  s = 1;  end
                5, 8: begin
                    w = $urandom_range(2, 64);
                    h = $urandom_range(2, 64);
                    s = $urandom_range(0, 15);
                end
                6: begin
                    w = $urandom_range(0, 8191);
                    h = $urandom_range(0, 8191);
                    s = $urandom_range(0, 15);
                end
                7:       begin w = 100;  h = 50;   s = 5;  end
                default: begin w = 1920; h = 1080; s = 2;  end
            endcase
            case (p % 3)
                0:       begin gap_max = 0;  stall_max <= 0;  end
                1:       begin gap_max = 4;  stall_max <= 6;  end
                default: begin gap_max = 30; stall_max <= 40; end
            endcase
            write_reg(C_REG_WIDTH, t_size'(w));
            write_reg(C_REG_HEIGHT, t_size'(h));
            write_reg(C_REG_SCALE, t_size'(($urandom & 32'h1FF0) | s));
            if (p % 2 == 1) begin
                write_reg(C_REG_SPARE, t_size'($urandom));
            end
            i_cfg_valid <= 1'b0;
            run_traffic(C_RANDOM_ITEMS / C_PHASES);
            wait_idle();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
